### hw/rtl/utf8_stream_decoder_macros.svh
// Assertion macros shared by the UTF-8 stream decoder RTL.
`ifndef UTF8_STREAM_DECODER_MACROS_SVH
`define UTF8_STREAM_DECODER_MACROS_SVH
`ifndef SYNTHESIS
`define UTF8SD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define UTF8SD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define UTF8SD_ASSERT(label, prop, msg)
`define UTF8SD_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

### hw/rtl/utf8sd_pkg.sv
// Types and constants of the UTF-8 stream decoder.
package utf8sd_pkg;

  localparam int MAX_RESULTS = 4;

  localparam logic [1:0] CONT_TAG  = 2'b10;
  localparam logic [2:0] LEAD2_TAG = 3'b110;
  localparam logic [3:0] LEAD3_TAG = 4'b1110;
  localparam logic [4:0] LEAD4_TAG = 5'b11110;

  localparam logic [2:0] LEN_NONE = 3'd0;
  localparam logic [2:0] LEN1     = 3'd1;
  localparam logic [2:0] LEN2     = 3'd2;
  localparam logic [2:0] LEN3     = 3'd3;
  localparam logic [2:0] LEN4     = 3'd4;

  typedef struct packed {
    logic [20:0] code_point;
    logic [2:0]  byte_count;
    logic        invalid;
    logic        last;
  } utf8sd_res_t;

  typedef struct packed {
    logic [2:0]                    num;
    utf8sd_res_t [MAX_RESULTS-1:0] slot;
  } utf8sd_batch_t;

endpackage

### hw/rtl/utf8sd_decode.sv
// Sequence state and per-item decode into a batch of results.
`include "utf8_stream_decoder_macros.svh"
module utf8sd_decode (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    accept,
  input  logic [7:0]              in_byte,
  input  logic                    end_of_text,
  output utf8sd_pkg::utf8sd_batch_t batch
);
  import utf8sd_pkg::*;

  logic [7:0] lead;
  logic [7:0] cont [2];
  logic [1:0] held;
  logic [2:0] exp_len;

  logic [7:0] lead_next;
  logic [7:0] cont_next [2];
  logic [1:0] held_next;
  logic [2:0] exp_len_next;

  always_comb begin
    logic [2:0]  n;
    logic [2:0]  n_m1;
    logic [20:0] cp;
    logic        is_cont;
    logic        do_lead;
    lead_next    = lead;
    cont_next    = cont;
    held_next    = held;
    exp_len_next = exp_len;
    batch        = '0;
    n            = 3'd0;
    cp           = '0;
    is_cont      = (in_byte[7:6] == CONT_TAG);
    do_lead      = 1'b0;

    if (exp_len != LEN_NONE) begin
      if (is_cont) begin
        if (({1'b0, held} + 3'd2) >= exp_len) begin
          case (exp_len)
            LEN2:    cp = {10'd0, lead[4:0], in_byte[5:0]};
            LEN3:    cp = {5'd0, lead[3:0], cont[0][5:0], in_byte[5:0]};
            default: cp = {lead[2:0], cont[0][5:0], cont[1][5:0], in_byte[5:0]};
          endcase
          batch.slot[n[1:0]].code_point = cp;
          batch.slot[n[1:0]].byte_count = exp_len;
          n            = n + 3'd1;
          exp_len_next = LEN_NONE;
          held_next    = 2'd0;
        end else begin
          cont_next[held[0]] = in_byte;
          held_next          = held + 2'd1;
        end
      end else begin
        // broken sequence: lead and held bytes go out as invalid singles
        batch.slot[n[1:0]].code_point = {13'd0, lead};
        batch.slot[n[1:0]].byte_count = LEN1;
        batch.slot[n[1:0]].invalid    = 1'b1;
        n = n + 3'd1;
        for (int i = 0; i < 2; i++) begin
          if (2'(i) < held) begin
            batch.slot[n[1:0]].code_point = {13'd0, cont[i]};
            batch.slot[n[1:0]].byte_count = LEN1;
            batch.slot[n[1:0]].invalid    = 1'b1;
            n = n + 3'd1;
          end
        end
        exp_len_next = LEN_NONE;
        held_next    = 2'd0;
        do_lead      = 1'b1;
      end
    end else begin
      do_lead = 1'b1;
    end

    if (do_lead && (in_byte != 8'd0)) begin
      if (!in_byte[7]) begin
        batch.slot[n[1:0]].code_point = {13'd0, in_byte};
        batch.slot[n[1:0]].byte_count = LEN1;
        n = n + 3'd1;
      end else if (in_byte[7:5] == LEAD2_TAG) begin
        lead_next    = in_byte;
        exp_len_next = LEN2;
        held_next    = 2'd0;
      end else if (in_byte[7:4] == LEAD3_TAG) begin
        lead_next    = in_byte;
        exp_len_next = LEN3;
        held_next    = 2'd0;
      end else if (in_byte[7:3] == LEAD4_TAG) begin
        lead_next    = in_byte;
        exp_len_next = LEN4;
        held_next    = 2'd0;
      end else begin
        batch.slot[n[1:0]].code_point = {13'd0, in_byte};
        batch.slot[n[1:0]].byte_count = LEN1;
        batch.slot[n[1:0]].invalid    = 1'b1;
        n = n + 3'd1;
      end
    end

    // end of text flushes whatever is still pending
    if (end_of_text && (exp_len_next != LEN_NONE)) begin
      batch.slot[n[1:0]].code_point = {13'd0, lead_next};
      batch.slot[n[1:0]].byte_count = LEN1;
      batch.slot[n[1:0]].invalid    = 1'b1;
      n = n + 3'd1;
      for (int i = 0; i < 2; i++) begin
        if (2'(i) < held_next) begin
          batch.slot[n[1:0]].code_point = {13'd0, cont_next[i]};
          batch.slot[n[1:0]].byte_count = LEN1;
          batch.slot[n[1:0]].invalid    = 1'b1;
          n = n + 3'd1;
        end
      end
      exp_len_next = LEN_NONE;
      held_next    = 2'd0;
    end

    n_m1 = n - 3'd1;
    if (n != 3'd0) begin
      batch.slot[n_m1[1:0]].last = 1'b1;
    end
    batch.num = n;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lead    <= '0;
      held    <= '0;
      exp_len <= LEN_NONE;
    end else if (accept) begin
      lead    <= lead_next;
      held    <= held_next;
      exp_len <= exp_len_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cont <= cont_next;
    end
  end

  `UTF8SD_ASSERT(a_idle_no_held, (exp_len != LEN_NONE) || (held == 2'd0), "held bytes while idle")
  `UTF8SD_ASSERT(a_held_short, (exp_len == LEN_NONE) || (({1'b0, held} + 3'd2) <= exp_len), "held count past length")

endmodule

### hw/rtl/utf8sd_burst.sv
// Result batch buffer draining one result per cycle into the output register while the output is free.
`include "utf8_stream_decoder_macros.svh"
module utf8sd_burst (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      load,
  input  utf8sd_pkg::utf8sd_batch_t batch,
  output logic                      can_load,
  output logic                      out_valid,
  input  logic                      out_ready,
  output utf8sd_pkg::utf8sd_res_t   out_res
);
  import utf8sd_pkg::*;

  utf8sd_res_t [MAX_RESULTS-1:0] slots;
  logic [2:0] rem;
  logic [1:0] ptr;
  logic       out_free;
  logic       take;

  assign out_free = !out_valid || out_ready;
  assign take     = out_free && (rem != 3'd0);
  assign can_load = (rem == 3'd0) || ((rem == 3'd1) && out_free);

  always_ff @(posedge clk) begin
    if (rst) begin
      rem       <= '0;
      ptr       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (take) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (load) begin
        rem <= batch.num;
        ptr <= '0;
      end else if (take) begin
        rem <= rem - 3'd1;
        ptr <= ptr + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_res <= slots[ptr];
    end
    if (load) begin
      slots <= batch.slot;
    end
  end

  `UTF8SD_ASSERT(a_rem_range, rem <= 3'd4, "batch count out of range")
  `UTF8SD_ASSERT_NEXT(a_drain, (rem != 3'd0) && !out_valid, out_valid, "batch not drained")

endmodule

### hw/rtl/utf8_stream_decoder.sv
// UTF-8 stream decoder: one byte in, zero to four code point results out.
// A result is held in the batch slots and then in the output register before it appears on m_*.
// Throughput: one byte per cycle while each byte gives at most one result and m_tready is high;
// a byte giving several results holds s_tready low as the batch drains down to its last result.
// Reset: rst synchronous, active high; clears pending sequence and buffers.
module utf8_stream_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,  // [7:0] in_byte
  input  logic        s_tlast,  // end_of_text
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,  // [20:0] code_point, [23:21] byte_count
  output logic        m_tuser,  // [0] invalid
  output logic        m_tlast   // last_of_run
);
  import utf8sd_pkg::*;

  utf8sd_batch_t batch;
  utf8sd_res_t   out_res;
  logic          accept;

  assign accept = s_tvalid && s_tready;

  utf8sd_decode u_decode (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .in_byte     (s_tdata),
    .end_of_text (s_tlast),
    .batch       (batch)
  );

  utf8sd_burst u_burst (
    .clk       (clk),
    .rst       (rst),
    .load      (accept),
    .batch     (batch),
    .can_load  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_res   (out_res)
  );

  assign m_tdata = {out_res.byte_count, out_res.code_point};
  assign m_tuser = out_res.invalid;
  assign m_tlast = out_res.last;

endmodule
